FILE: rtl/c32rc_pkg.sv
// ----------------------------------------------------------------------------
// CRC-32 response checker package
// Shared types, constants and the single-byte CRC-32 function.
// ----------------------------------------------------------------------------
package c32rc_pkg;

  localparam logic [7:0]  StartMark = 8'h7C;
  localparam logic [31:0] CrcPoly   = 32'hEDB88320;
  localparam logic [31:0] CrcInit   = 32'hFFFFFFFF;
  localparam logic [31:0] CrcXorOut = 32'hFFFFFFFF;

  // group phase: start mark, four checksum bytes, one data byte
  localparam logic [2:0] PhaseStart = 3'd0;
  localparam logic [2:0] PhaseCrc0  = 3'd1;
  localparam logic [2:0] PhaseCrc1  = 3'd2;
  localparam logic [2:0] PhaseData  = 3'd5;

  typedef enum logic [1:0] {
    FaultNone       = 2'd0,
    FaultStart      = 2'd1,
    FaultCrc        = 2'd2,
    FaultIncomplete = 2'd3
  } fault_e;

  // reflected CRC-32 of one byte, one shift step per bit
  function automatic logic [31:0] crc_of_byte(input logic [7:0] b);
    logic [31:0] c;
    c = CrcInit ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c ^ CrcXorOut;
  endfunction

endpackage

FILE: rtl/c32rc_in_if.sv
// ----------------------------------------------------------------------------
// CRC-32 response checker input channel
// Valid/ready channel carrying one received byte and its last flag.
// ----------------------------------------------------------------------------
interface c32rc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       last_byte;

  modport source (output valid, output rx_byte, output last_byte, input ready);
  modport sink   (input valid, input rx_byte, input last_byte, output ready);
endinterface

FILE: rtl/c32rc_out_if.sv
// ----------------------------------------------------------------------------
// CRC-32 response checker output channel
// Valid/ready channel carrying a checked data byte and the message verdict.
// ----------------------------------------------------------------------------
interface c32rc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       data_present;
  logic       end_of_message;
  logic       message_ok;
  logic [1:0] fault_code;

  modport source (output valid, output data_byte, output data_present,
                  output end_of_message, output message_ok, output fault_code,
                  input ready);
  modport sink   (input valid, input data_byte, input data_present,
                  input end_of_message, input message_ok, input fault_code,
                  output ready);
endinterface

FILE: rtl/crc32_response_checker_top.sv
// ----------------------------------------------------------------------------
// CRC-32 response checker
// Path: input register, then result register; the per-byte CRC and the
// check sit between them. Throughput: one byte per cycle unless out_o.ready
// is low with a result held, set by the single-pass byte CRC logic.
// Reset clears the stage valids, the group phase, checksum and fault state.
// ----------------------------------------------------------------------------
module crc32_response_checker_top (
  input  logic clk_i,
  input  logic rst_ni,
  c32rc_in_if.sink    in_i,
  c32rc_out_if.source out_o
);

  // input register
  logic       s1_valid_q, s1_valid_d;
  logic [7:0] s1_byte_q;
  logic       s1_last_q;
  logic       s1_adv;

  // message state
  logic [2:0]        phase_q, phase_d;
  logic [31:0]       shift_q, shift_d;
  c32rc_pkg::fault_e fault_q, fault_d;

  // result register
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_data_q;
  logic       out_present_q;
  logic       out_end_q;
  logic       out_ok_q;
  logic [1:0] out_fault_q;

  logic              have_data;
  logic              produce;
  logic [2:0]        ph;
  logic [2:0]        ph_next;
  logic [31:0]       shift_upd;
  c32rc_pkg::fault_e fault_upd;
  c32rc_pkg::fault_e verdict;

  assign s1_adv     = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_adv;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_i.ready) begin
      s1_valid_d = in_i.valid;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_byte_q <= in_i.rx_byte;
      s1_last_q <= in_i.last_byte;
    end
  end

  // byte check
  always_comb begin
    ph        = (phase_q > c32rc_pkg::PhaseData) ? c32rc_pkg::PhaseCrc0 : phase_q;
    ph_next   = c32rc_pkg::PhaseCrc0;
    shift_upd = shift_q;
    fault_upd = fault_q;
    have_data = 1'b0;
    case (ph)
      c32rc_pkg::PhaseStart: begin
        if (s1_byte_q != c32rc_pkg::StartMark && fault_q == c32rc_pkg::FaultNone) begin
          fault_upd = c32rc_pkg::FaultStart;
        end
        shift_upd = '0;
      end
      c32rc_pkg::PhaseData: begin
        if (fault_q == c32rc_pkg::FaultNone) begin
          if (c32rc_pkg::crc_of_byte(s1_byte_q) == shift_q) begin
            have_data = 1'b1;
          end else begin
            fault_upd = c32rc_pkg::FaultCrc;
          end
        end
      end
      default: begin
        shift_upd = {shift_q[23:0], s1_byte_q};
        ph_next   = ph + 3'd1;
      end
    endcase

    verdict = fault_upd;
    if (fault_upd == c32rc_pkg::FaultNone && ph_next != c32rc_pkg::PhaseCrc0) begin
      verdict = c32rc_pkg::FaultIncomplete;
    end
    produce = have_data || s1_last_q;

    phase_d = phase_q;
    shift_d = shift_q;
    fault_d = fault_q;
    if (s1_adv) begin
      if (s1_last_q) begin
        // return to waiting for a start mark
        phase_d = c32rc_pkg::PhaseStart;
        shift_d = '0;
        fault_d = c32rc_pkg::FaultNone;
      end else begin
        phase_d = ph_next;
        shift_d = shift_upd;
        fault_d = fault_upd;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= c32rc_pkg::PhaseStart;
      shift_q <= '0;
      fault_q <= c32rc_pkg::FaultNone;
    end else begin
      phase_q <= phase_d;
      shift_q <= shift_d;
      fault_q <= fault_d;
    end
  end

  // result register: hold until the transfer completes
  always_comb begin
    out_valid_d = out_valid_q && !out_o.ready;
    if (s1_adv) begin
      out_valid_d = produce;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && produce) begin
      out_data_q    <= have_data ? s1_byte_q : 8'd0;
      out_present_q <= have_data;
      out_end_q     <= s1_last_q;
      out_ok_q      <= s1_last_q && (verdict == c32rc_pkg::FaultNone);
      out_fault_q   <= s1_last_q ? verdict : c32rc_pkg::FaultNone;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.data_byte      = out_data_q;
  assign out_o.data_present   = out_present_q;
  assign out_o.end_of_message = out_end_q;
  assign out_o.message_ok     = out_ok_q;
  assign out_o.fault_code     = out_fault_q;

  // assertions
  a_result_has_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_present_q || out_end_q))
    else $error("result with neither data nor end of message");

  a_ok_means_no_fault: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_end_q) |->
      (out_ok_q == (out_fault_q == c32rc_pkg::FaultNone)))
    else $error("verdict and fault code disagree");

  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q <= c32rc_pkg::PhaseData)
    else $error("group phase out of range");

  a_last_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && s1_last_q) |=>
      (phase_q == c32rc_pkg::PhaseStart && fault_q == c32rc_pkg::FaultNone))
    else $error("message state not cleared after last byte");

  a_no_data_after_fault: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && fault_q != c32rc_pkg::FaultNone) |=> !(out_valid_q && out_present_q))
    else $error("data passed on after a fault");

endmodule
